/* sv/bfhp_pkg.sv */
// Bit-field header packer: shared types and constants.
// No dependencies; imported by every module of the block.
package bfhp_pkg;

	localparam int MAX_FIELD_BITS = 64;
	localparam int BYTE_W         = 8;
	localparam int LEN_W          = 7;
	localparam int CHAN_W         = 16;
	localparam int CNT_W          = 3;

	// request to the shared shifter
	typedef struct packed {
		logic [MAX_FIELD_BITS-1:0] data;
		logic [LEN_W-1:0]          amt;
	} shift_req_t;

	// one result byte on its way to the output register
	typedef struct packed {
		logic              push;
		logic [BYTE_W-1:0] data;
		logic              last;
	} res_t;

endpackage

/* sv/bit_field_header_packer.sv */
// Top level of the bit-field header packer: sequencer, channel register.
// Depends on bfhp_pkg, bfhp_shift and bfhp_obuf.
//
// channel  signals                                    dir  transaction
// input    in_valid/in_ready, field_value,            in   one field
//          field_length, last_field
// output   out_valid/out_ready, out_byte, last_byte   out  one header byte
// config   cfg_we, cfg_wdata                          in   channel number
//
// A field is accepted and aligned in idle; the first field of a packet then
// sends the two channel bytes, then the packed bytes go out one per cycle through
// the shared shifter, with a closing step when the field packs no byte or
// leaves a partial byte pending; out_ready low stalls the sequencer.
// Reset clears the channel number, the partial byte and the packet state.
// in_ready is high in idle even while the last byte waits in the output stage.
module bit_field_header_packer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bfhp_pkg::MAX_FIELD_BITS-1:0] field_value,
	input  logic [bfhp_pkg::LEN_W-1:0]          field_length,
	input  logic                                last_field,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bfhp_pkg::BYTE_W-1:0]         out_byte,
	output logic                                last_byte,
	input  logic                                cfg_we,
	input  logic [bfhp_pkg::CHAN_W-1:0]         cfg_wdata
);
	import bfhp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CH_LO,
		ST_CH_HI,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic [MAX_FIELD_BITS-1:0] fld_q;
	logic [LEN_W-1:0]          rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [BYTE_W-1:0]         acc_q;
	logic                      open_q;
	logic                      last_q;
	logic [CHAN_W-1:0]         channel_q;

	logic [LEN_W-1:0]          sat_len;
	logic [LEN_W-1:0]          total;
	logic [LEN_W-1:0]          take;
	logic [BYTE_W-1:0]         byte_c;
	logic                      want_emit;
	logic                      space;
	logic                      accept;
	shift_req_t                sreq;
	logic [MAX_FIELD_BITS-1:0] shifted;
	res_t                      res;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign sat_len   = (field_length > LEN_W'(MAX_FIELD_BITS)) ?
	                   LEN_W'(MAX_FIELD_BITS) : field_length;
	assign total     = LEN_W'(cnt_q) + rem_q;
	assign take      = LEN_W'(BYTE_W) - LEN_W'(cnt_q);
	assign byte_c    = acc_q | (fld_q[MAX_FIELD_BITS-1 -: BYTE_W] >> cnt_q);
	assign want_emit = (total >= LEN_W'(BYTE_W)) || (last_q && (total != '0));

	always_comb begin
		if (state_q == ST_IDLE) begin
			sreq.data = field_value;
			sreq.amt  = LEN_W'(MAX_FIELD_BITS) - sat_len;
		end else begin
			sreq.data = fld_q;
			sreq.amt  = take;
		end
	end

	bfhp_shift u_shift (
		.req    (sreq),
		.result (shifted)
	);

	always_comb begin
		res = '0;
		case (state_q)
			ST_CH_LO: begin
				res.push = 1'b1;
				res.data = channel_q[BYTE_W-1:0];
			end
			ST_CH_HI: begin
				res.push = 1'b1;
				res.data = channel_q[CHAN_W-1 -: BYTE_W];
				res.last = last_q && (rem_q == '0);
			end
			ST_EMIT: begin
				res.push = want_emit;
				res.data = byte_c;
				res.last = last_q && (total <= LEN_W'(BYTE_W));
			end
			default: begin
				res = '0;
			end
		endcase
	end

	bfhp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
		end else if (cfg_we) begin
			channel_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fld_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			open_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fld_q   <= shifted;
						rem_q   <= sat_len;
						last_q  <= last_field;
						state_q <= open_q ? ST_EMIT : ST_CH_LO;
					end
				end
				ST_CH_LO: begin
					if (space) begin
						open_q  <= 1'b1;
						state_q <= ST_CH_HI;
					end
				end
				ST_CH_HI: begin
					if (space) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!want_emit) begin
						// partial byte stays pending, or an empty last field closes
						rem_q   <= '0;
						state_q <= ST_IDLE;
						if (last_q) begin
							cnt_q  <= '0;
							acc_q  <= '0;
							open_q <= 1'b0;
						end else begin
							cnt_q <= total[CNT_W-1:0];
							acc_q <= byte_c;
						end
					end else if (space) begin
						cnt_q <= '0;
						acc_q <= '0;
						fld_q <= shifted;
						if (total > LEN_W'(BYTE_W)) begin
							rem_q <= rem_q - take;
						end else begin
							rem_q   <= '0;
							state_q <= ST_IDLE;
							if (last_q) begin
								open_q <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_first_field_sends_channel: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !open_q |=> state_q == ST_CH_LO)
		else $error("first field of a packet did not start with the channel bytes");

	a_closed_has_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (cnt_q == '0) && (acc_q == '0))
		else $error("pending bits held while no packet is open");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= LEN_W'(MAX_FIELD_BITS))
		else $error("remaining field bits out of range");

	a_last_closes_packet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && res.push && res.last && space |=>
		state_q == ST_IDLE && !open_q)
		else $error("packet still open after its last byte");

endmodule

/* sv/bfhp_shift.sv */
// Shared left shifter: aligns a new field and consumes bytes from it.
// Depends on bfhp_pkg.
module bfhp_shift (
	input  bfhp_pkg::shift_req_t                    req,
	output logic [bfhp_pkg::MAX_FIELD_BITS-1:0]     result
);
	import bfhp_pkg::*;

	// shift amounts of MAX_FIELD_BITS and above give zero
	always_comb begin
		if (req.amt >= LEN_W'(MAX_FIELD_BITS)) begin
			result = '0;
		end else begin
			result = req.data << req.amt;
		end
	end

endmodule

/* sv/bfhp_obuf.sv */
// Output register for the byte channel; it stalls the sequencer only while full and out_ready is low.
// Depends on bfhp_pkg.
module bfhp_obuf (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfhp_pkg::res_t               res,
	output logic                         space,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bfhp_pkg::BYTE_W-1:0]  out_byte,
	output logic                         last_byte
);
	import bfhp_pkg::*;

	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last_byte = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= res.push;
		end
	end

	always_ff @(posedge clk) begin
		if (space && res.push) begin
			byte_q <= res.data;
			last_q <= res.last;
		end
	end

endmodule
